>>> src/cmwc_pkg.sv
// Package for the CMWC4096 random generator.
// Holds the word types, the scheme constants and the memory write bundle.
// No dependencies; imported by every module of the block.
package cmwc_pkg;

    localparam int WORD_W = 32;
    localparam int CARRY_W = 20;
    localparam int MULT_W = 15;
    localparam int PROD_W = WORD_W + MULT_W;

    localparam int DEF_TABLE_DEPTH = 4096;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CARRY_W-1:0] carry_t;

    localparam word_t PHI_CONST = 32'h9e37_79b9;
    localparam logic [MULT_W-1:0] MULT_CONST = 15'd18782;
    localparam word_t COMP_CONST = 32'hffff_fffe;
    localparam carry_t CARRY_RESET = 20'd362436;

    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    typedef struct packed {
        logic  we;
        word_t wdata;
    } mem_wr_t;

endpackage

>>> src/cmwc_lag_ram.sv
// Lag table storage: single-port synchronous RAM with a registered read.
// Depends on cmwc_pkg for the word type and the write bundle.
module cmwc_lag_ram #(
    parameter int TABLE_DEPTH = cmwc_pkg::DEF_TABLE_DEPTH,
    parameter int ADDR_W = $clog2(TABLE_DEPTH)
) (
    input  logic                  clk,
    input  logic [ADDR_W-1:0]     addr,
    input  cmwc_pkg::mem_wr_t     wr,
    output cmwc_pkg::word_t       rdata
);
    import cmwc_pkg::*;

    word_t mem [TABLE_DEPTH];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[addr];
        if (wr.we)
        begin
            mem[addr] <= wr.wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/cmwc_seed_fill.sv
// Seed sequencer: writes one lag table word per cycle over the whole table.
// Depends on cmwc_pkg; drives the RAM write port while a seed is running.
module cmwc_seed_fill #(
    parameter int TABLE_DEPTH = cmwc_pkg::DEF_TABLE_DEPTH,
    parameter int ADDR_W = $clog2(TABLE_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  cmwc_pkg::word_t       seed,
    output logic                  busy,
    output logic [ADDR_W-1:0]     addr,
    output cmwc_pkg::mem_wr_t     wr
);
    import cmwc_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] IDX_ONE = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] IDX_TWO = ADDR_W'(2);

    logic active_reg;
    logic active_next;
    logic [ADDR_W-1:0] k_reg;
    logic [ADDR_W-1:0] k_next;
    word_t seed_reg;
    word_t w1_reg;
    word_t w2_reg;
    word_t w3_reg;
    word_t word_val;

    always_comb
    begin
        if (k_reg == '0)
        begin
            word_val = seed_reg;
        end
        else if (k_reg == IDX_ONE || k_reg == IDX_TWO)
        begin
            word_val = w1_reg + PHI_CONST;
        end
        else
        begin
            word_val = w3_reg ^ w2_reg ^ PHI_CONST ^ {{(WORD_W-ADDR_W){1'b0}}, k_reg};
        end
    end

    always_comb
    begin
        active_next = active_reg;
        k_next = k_reg;
        if (start)
        begin
            active_next = 1'b1;
            k_next = '0;
        end
        else if (active_reg)
        begin
            k_next = k_reg + IDX_ONE;
            if (k_reg == LAST_IDX)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            k_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            k_reg <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            seed_reg <= seed;
        end
        if (active_reg)
        begin
            w1_reg <= word_val;
            w2_reg <= w1_reg;
            w3_reg <= w2_reg;
        end
    end

    assign busy = active_reg;
    assign addr = k_reg;
    assign wr.we = active_reg;
    assign wr.wdata = word_val;

endmodule

>>> src/cmwc_draw_unit.sv
// Draw datapath: index step, table read, constant multiply, carry update
// and write-back. Depends on cmwc_pkg; owns the carry and index registers.
module cmwc_draw_unit #(
    parameter int TABLE_DEPTH = cmwc_pkg::DEF_TABLE_DEPTH,
    parameter int ADDR_W = $clog2(TABLE_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  cmwc_pkg::word_t       rdata,
    output logic                  busy,
    output logic [ADDR_W-1:0]     addr,
    output cmwc_pkg::mem_wr_t     wr,
    output logic                  result_valid,
    output cmwc_pkg::word_t       result_word
);
    import cmwc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_MUL = 2'd2;
    localparam logic [1:0] ST_WB = 2'd3;
    localparam logic [ADDR_W-1:0] INDEX_RESET = ADDR_W'(TABLE_DEPTH - 1);

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [ADDR_W-1:0] index_reg;
    logic [ADDR_W-1:0] index_next;
    carry_t carry_reg;
    carry_t carry_next;
    logic valid_reg;
    logic valid_next;
    word_t word_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W:0] t_sum;
    logic [PROD_W-WORD_W:0] carry_hi;
    word_t x_sum;
    logic wrap;
    word_t x_fin;
    word_t wb_word;

    always_comb
    begin
        t_sum = {1'b0, prod_reg} + (PROD_W + 1)'(carry_reg);
        carry_hi = t_sum[PROD_W:WORD_W];
        x_sum = t_sum[WORD_W-1:0] + WORD_W'(carry_hi);
        wrap = x_sum < WORD_W'(carry_hi);
        x_fin = x_sum + WORD_W'(wrap);
        wb_word = COMP_CONST - x_fin;
    end

    always_comb
    begin
        state_next = state_reg;
        index_next = index_reg;
        carry_next = carry_reg;
        valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                    index_next = index_reg + ADDR_W'(1);
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                state_next = ST_IDLE;
                carry_next = CARRY_W'(carry_hi) + CARRY_W'(wrap);
                valid_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            index_reg <= INDEX_RESET;
            carry_reg <= CARRY_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            index_reg <= index_next;
            carry_reg <= carry_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(rdata) * PROD_W'(MULT_CONST);
        end
        if (state_reg == ST_WB)
        begin
            word_reg <= wb_word;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign addr = index_reg;
    assign wr.we = (state_reg == ST_WB);
    assign wr.wdata = wb_word;
    assign result_valid = valid_reg;
    assign result_word = word_reg;

endmodule

>>> src/cmwc4096_random_generator.sv
// Top level of the CMWC4096 random generator.
// Depends on cmwc_pkg, cmwc_lag_ram, cmwc_seed_fill and cmwc_draw_unit.
//
// A transaction is taken when start is high and busy is low. A seed command
// (cmd low) writes the lag table one word per clock and keeps busy high until
// the whole table is written; it returns nothing and leaves the carry and
// index as they were. A draw command (cmd high) keeps busy high in the read,
// multiply and write-back states, while the single RAM port is read, the
// constant product is registered and the new word is written back; valid
// then pulses for exactly one cycle with random_word, and the receiver cannot
// stall it. A new draw is accepted only once the read-multiply-write sequence
// on the one table port is through. The table holds no defined data until the
// first seed, so a draw must not be issued before one.
module cmwc4096_random_generator #(
    parameter int TABLE_DEPTH = cmwc_pkg::DEF_TABLE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  cmd,
    input  cmwc_pkg::word_t       seed,
    output logic                  valid,
    output cmwc_pkg::word_t       random_word
);
    import cmwc_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic accept;
    logic seed_start;
    logic draw_start;
    logic seed_busy;
    logic draw_busy;
    logic [ADDR_W-1:0] seed_addr;
    logic [ADDR_W-1:0] draw_addr;
    logic [ADDR_W-1:0] ram_addr;
    mem_wr_t seed_wr;
    mem_wr_t draw_wr;
    mem_wr_t ram_wr;
    word_t ram_rdata;

    assign busy = seed_busy | draw_busy;
    assign accept = start & ~busy;
    assign seed_start = accept & (cmd == CMD_SEED);
    assign draw_start = accept & (cmd == CMD_DRAW);

    assign ram_addr = seed_busy ? seed_addr : draw_addr;
    assign ram_wr = seed_busy ? seed_wr : draw_wr;

    cmwc_lag_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .wr    (ram_wr),
        .rdata (ram_rdata)
    );

    cmwc_seed_fill #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_seed (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seed_start),
        .seed  (seed),
        .busy  (seed_busy),
        .addr  (seed_addr),
        .wr    (seed_wr)
    );

    cmwc_draw_unit #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_draw (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (draw_start),
        .rdata        (ram_rdata),
        .busy         (draw_busy),
        .addr         (draw_addr),
        .wr           (draw_wr),
        .result_valid (valid),
        .result_word  (random_word)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        !(seed_busy && draw_busy))
        else $error("Seed and draw sequences overlap on the table port.");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("Result strobe lasted more than one cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(draw_busy) && !seed_busy)
        else $error("Result strobe without a finished draw.");

    assert property (@(posedge clk) disable iff (!rst_n)
        seed_start |=> seed_busy && !valid)
        else $error("Accepted seed transaction did not start the fill.");

endmodule

>>> tb/tb_cmwc4096_random_generator.sv
// Testbench for cmwc4096_random_generator: a directed table, then random seed and draw commands.
// Depends on cmwc_pkg and the generator RTL; every draw is checked against an in-bench model or a known word.
module tb_cmwc4096_random_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import cmwc_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam logic [11:0] INDEX_START = 12'(DEPTH - 1);
    localparam int RANDOM_ITEMS = 1032;
    localparam int STALL_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 12;
    localparam int N_DIRECTED = 18;

    typedef struct packed {
        logic  cmd;
        word_t seed;
        logic  known;
        word_t word;
    } stim_row_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  cmd = CMD_SEED;
    word_t seed = '0;
    logic  busy;
    logic  valid;
    word_t random_word;

    word_t       lag_words [DEPTH];
    carry_t      run_carry;
    logic [11:0] run_index;
    word_t       draw_queue [$];
    int          error_count = 0;
    int          stall_cycles = 0;
    bit          steady = 1'b0;

    // The first draw lands on the carry wrap: seed 0xffffffec with the reset carry.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{CMD_SEED, 32'hffff_ffec, 1'b0, 32'h0000_0000},
        '{CMD_DRAW, 32'h0000_0000, 1'b1, 32'hffff_ea34},
        '{CMD_DRAW, 32'hffff_ffff, 1'b0, 32'h0000_0000},
        '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{CMD_SEED, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{CMD_DRAW, 32'hffff_ffff, 1'b0, 32'h0000_0000},
        '{CMD_SEED, 32'hffff_ffff, 1'b0, 32'h0000_0000},
        '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{CMD_SEED, 32'ha5a5_a5a5, 1'b0, 32'h0000_0000},
        '{CMD_SEED, 32'h5a5a_5a5a, 1'b0, 32'h0000_0000},
        '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{CMD_DRAW, 32'h8000_0000, 1'b0, 32'h0000_0000},
        '{CMD_DRAW, 32'h1234_5678, 1'b0, 32'h0000_0000},
        '{CMD_SEED, 32'h8000_0000, 1'b0, 32'h0000_0000},
        '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{CMD_DRAW, 32'h7fff_ffff, 1'b0, 32'h0000_0000}
    };

    cmwc4096_random_generator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .seed        (seed),
        .valid       (valid),
        .random_word (random_word)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void fill_lag_words(input word_t s);
        lag_words[0] = s;
        lag_words[1] = s + PHI_CONST;
        lag_words[2] = s + PHI_CONST + PHI_CONST;
        for (int k = 3; k < DEPTH; k++)
            lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ PHI_CONST ^ word_t'(k);
    endfunction

    function automatic word_t next_draw_word();
        logic [63:0] product;
        word_t       low_sum;
        run_index = run_index + 12'd1;
        product = 64'(MULT_CONST) * 64'(lag_words[run_index]) + 64'(run_carry);
        run_carry = carry_t'(product[63:32]);
        low_sum = product[31:0] + word_t'(run_carry);
        if (low_sum < word_t'(run_carry))
        begin
            low_sum = low_sum + 32'd1;
            run_carry = run_carry + 20'd1;
        end
        lag_words[run_index] = COMP_CONST - low_sum;
        return lag_words[run_index];
    endfunction

    task automatic log_error(input string what, input word_t want, input word_t got);
        error_count++;
        if (error_count <= 10)
            $display("error: %s: expected %h, got %h", what, want, got);
    endtask

    task automatic enqueue_draw(input word_t w);
        draw_queue = {draw_queue, w};
    endtask

    task automatic issue(input logic c, input word_t s, input logic known, input word_t w);
        word_t predicted;
        while (!steady && $urandom_range(99) < 23)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        seed <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (c == CMD_DRAW)
        begin
            predicted = next_draw_word();
            enqueue_draw(known ? w : predicted);
        end
        else
            fill_lag_words(s);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || valid)
                stall_cycles = 0;
            else
            begin
                stall_cycles = stall_cycles + 1;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("status: fail");
                    $finish;
                end
            end
            if (valid)
            begin
                if (draw_queue.size() == 0)
                    log_error("random_word with no draw pending", '0, random_word);
                else if (random_word !== draw_queue[0])
                begin
                    log_error("random_word", draw_queue[0], random_word);
                    void'(draw_queue.pop_front());
                end
                else
                    void'(draw_queue.pop_front());
            end
        end
    end

    initial
    begin
        run_carry = CARRY_RESET;
        run_index = INDEX_START;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue(directed_rows[i].cmd, directed_rows[i].seed,
                  directed_rows[i].known, directed_rows[i].word);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 400 && n < 600);
            if ($urandom_range(79) == 0)
                issue(CMD_SEED, $urandom, 1'b0, '0);
            else
                issue(CMD_DRAW, $urandom, 1'b0, '0);
        end

        steady = 1'b0;
        start <= 1'b0;
        @(posedge clk);
        while (draw_queue.size() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (draw_queue.size() != 0)
            log_error("draws left without a result", draw_queue[0], '0);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
src/cmwc_pkg.sv
src/cmwc_lag_ram.sv
src/cmwc_seed_fill.sv
src/cmwc_draw_unit.sv
src/cmwc4096_random_generator.sv
tb/tb_cmwc4096_random_generator.sv
